// ----- rtl/core/wmv_pkg.sv -----
// wmv_pkg: shared widths, types and helper functions for the window mean/variance filter
// no dependencies; used by wmv_ring, wmv_div and window_mean_variance_filter
package wmv_pkg;

  // sizing of window and samples
  localparam int WindowMax   = 16;
  localparam int SampleBits  = 16;
  localparam int FracBits    = 8;

  // fixed field widths of the ports
  localparam int InFieldBits = 16;
  localparam int LenBits     = 5;
  localparam int MeanOutBits = 24;
  localparam int VarBits     = 38;
  localparam int CfgIdxBits  = 4;
  localparam int CfgDataBits = 8;

  // register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] RegWindowLength  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegDifferenceMode = CfgIdxBits'(1);

  // derived widths
  localparam int IdxBits     = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int CntBits     = $clog2(WindowMax + 1);
  localparam int SumBits     = SampleBits + IdxBits;
  localparam int MeanBits    = SampleBits + FracBits;
  localparam int SqBits      = 2 * MeanBits;
  localparam int AccBits     = SqBits + IdxBits;
  localparam int DivBits     = AccBits - FracBits;
  localparam int DivCntBits  = $clog2(DivBits);
  localparam int ExtBits     = DivBits + VarBits + MeanOutBits;
  localparam int InDataBits  = ((InFieldBits + 7) / 8) * 8;
  localparam int OutDataBits = ((MeanOutBits + VarBits + 7) / 8) * 8;

  // ring write port
  typedef struct packed {
    logic                  en;
    logic [IdxBits-1:0]    addr;
    logic [SampleBits-1:0] data;
  } ring_wr_t;

  // divider request
  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] dividend;
    logic [CntBits-1:0] divisor;
  } div_req_t;

  // window length clamped to 1..WindowMax
  function automatic logic [CntBits-1:0] eff_len(input logic [LenBits-1:0] wl);
    int w;
    w = int'(wl);
    if (w == 0) begin
      return CntBits'(1);
    end else if (w > WindowMax) begin
      return CntBits'(WindowMax);
    end
    return CntBits'(w);
  endfunction

  // clip a quotient to the mean field
  function automatic logic [MeanOutBits-1:0] sat_mean(input logic [DivBits-1:0] q);
    logic [ExtBits-1:0] qx;
    logic [ExtBits-1:0] lim;
    qx  = ExtBits'(q);
    lim = ExtBits'({MeanOutBits{1'b1}});
    return (qx > lim) ? {MeanOutBits{1'b1}} : qx[MeanOutBits-1:0];
  endfunction

  // clip a quotient to the variance field
  function automatic logic [VarBits-1:0] sat_var(input logic [DivBits-1:0] q);
    logic [ExtBits-1:0] qx;
    logic [ExtBits-1:0] lim;
    qx  = ExtBits'(q);
    lim = ExtBits'({VarBits{1'b1}});
    return (qx > lim) ? {VarBits{1'b1}} : qx[VarBits-1:0];
  endfunction

endpackage

// ----- rtl/core/wmv_ring.sv -----
// wmv_ring: window ring memory, one write and one registered read port per cycle
// depends on wmv_pkg; entries not written since the last clear read as zero
module wmv_ring (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  wmv_pkg::ring_wr_t              wr_i,
  input  logic [wmv_pkg::IdxBits-1:0]    rd_addr_i,
  output logic [wmv_pkg::SampleBits-1:0] rd_data_o
);

  logic [wmv_pkg::SampleBits-1:0] mem [wmv_pkg::WindowMax];
  logic [wmv_pkg::WindowMax-1:0]  valid_q;
  logic [wmv_pkg::SampleBits-1:0] rd_data_q;
  logic                           rd_valid_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // per-entry valid bits, cleared at reset and on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/wmv_div.sv -----
// wmv_div: restoring divider, one quotient bit per cycle, shared by mean and variance
// depends on wmv_pkg; done_o pulses for one cycle with the quotient valid
module wmv_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wmv_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [wmv_pkg::DivBits-1:0] quot_o
);

  logic [wmv_pkg::DivBits-1:0]    quot_q;
  logic [wmv_pkg::CntBits-1:0]    rem_q;
  logic [wmv_pkg::CntBits-1:0]    dsr_q;
  logic [wmv_pkg::DivCntBits-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [wmv_pkg::CntBits:0]      trial;
  logic [wmv_pkg::CntBits:0]      diff;
  logic                           ge;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, quot_q[wmv_pkg::DivBits-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[wmv_pkg::CntBits-1:0] : trial[wmv_pkg::CntBits-1:0];
      quot_q <= {quot_q[wmv_pkg::DivBits-2:0], ge};
    end
  end

  // bit counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= wmv_pkg::DivCntBits'(wmv_pkg::DivBits - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/core/window_mean_variance_filter.sv -----
// Sliding-window mean and population variance of an unsigned sample stream. Each sample
// beat (or its absolute difference to the previous sample in difference mode) enters a
// ring of N entries; the result beat carries the mean and the variance, both Q8 and
// truncated. The next sample beat can be taken once the result of the previous one has
// entered the output register. The work per sample, in order of the states idle, update,
// mean division, variance pass, variance division and output:
//   - a 44-bit restoring divider, shared by the mean and the variance, retires one
//     quotient bit per cycle and then raises done, for the mean and for the variance
//   - the squared-deviation pass reads one ring entry per cycle and then drains a
//     three-stage square and accumulate pipeline
//   - the update, output and idle steps are one state each; output waits for a free output register
// The input is not ready while a sample is in work. A finished result waits in the output
// register and the next sample may enter meanwhile. A result that finds the output register
// still full holds the block until that result beat is taken. A write to the window length
// or difference mode register clears ring, sum, position and previous sample.
// depends on wmv_pkg, wmv_ring, wmv_div
module window_mean_variance_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wmv_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [wmv_pkg::CfgDataBits-1:0]    cfg_data_i,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [wmv_pkg::InDataBits-1:0]     s_axis_tdata,  // [15:0] sample
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [wmv_pkg::OutDataBits-1:0]    m_axis_tdata   // [23:0] mean_q8, [61:24] variance_q8
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StUpd  = 3'd1;
  localparam logic [2:0] StMdiv = 3'd2;
  localparam logic [2:0] StVar  = 3'd3;
  localparam logic [2:0] StVdiv = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]                         state_q, state_d;
  logic [wmv_pkg::LenBits-1:0]        wl_q;
  logic                               dm_q;
  logic [wmv_pkg::SampleBits-1:0]     prev_q;
  logic [wmv_pkg::SampleBits-1:0]     v_q;
  logic [wmv_pkg::IdxBits-1:0]        pos_q;
  logic [wmv_pkg::SumBits-1:0]        sum_q;
  logic [wmv_pkg::MeanOutBits-1:0]    mean_q;
  logic [wmv_pkg::VarBits-1:0]        var_q;
  logic [wmv_pkg::CntBits-1:0]        iss_q;
  logic                               p1_q, dv_q, sv_q;
  logic [wmv_pkg::MeanBits-1:0]       d_q;
  logic [wmv_pkg::SqBits-1:0]         sq_q;
  logic [wmv_pkg::AccBits-1:0]        acc_q;
  logic [wmv_pkg::MeanOutBits-1:0]    mean_out_q;
  logic [wmv_pkg::VarBits-1:0]        var_out_q;
  logic                               out_valid_q;

  logic [wmv_pkg::CntBits-1:0]        n;
  logic [wmv_pkg::SampleBits-1:0]     s;
  logic [wmv_pkg::SampleBits-1:0]     v;
  logic [wmv_pkg::IdxBits-1:0]        pos_eff;
  logic [wmv_pkg::CntBits-1:0]        pos_inc;
  logic [wmv_pkg::SumBits-1:0]        sum_new;
  logic [wmv_pkg::MeanBits-1:0]       e;
  logic [wmv_pkg::MeanBits-1:0]       mean_x;
  logic                               issue;
  logic                               var_done;
  logic                               in_acc;
  logic                               cfg_acc;
  logic                               clr;
  logic                               out_free;
  wmv_pkg::ring_wr_t                  ring_wr;
  logic [wmv_pkg::IdxBits-1:0]        rd_addr;
  logic [wmv_pkg::SampleBits-1:0]     rd_data;
  wmv_pkg::div_req_t                  div_req;
  logic                               div_done;
  logic [wmv_pkg::DivBits-1:0]        div_quot;

  // handshakes; a pending config write goes first
  assign cfg_ready_o   = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign clr           = cfg_acc && ((cfg_index_i == wmv_pkg::RegWindowLength) ||
                                     (cfg_index_i == wmv_pkg::RegDifferenceMode));
  assign out_free      = !out_valid_q || m_axis_tready;

  // window value of the incoming sample
  always_comb begin
    n = wmv_pkg::eff_len(wl_q);
    s = wmv_pkg::SampleBits'(s_axis_tdata[wmv_pkg::InFieldBits-1:0]);
    if (dm_q) begin
      v = (s >= prev_q) ? (s - prev_q) : (prev_q - s);
    end else begin
      v = s;
    end
    pos_eff = (wmv_pkg::CntBits'(pos_q) >= n) ? '0 : pos_q;
    pos_inc = wmv_pkg::CntBits'(pos_q) + 1'b1;
    sum_new = sum_q - wmv_pkg::SumBits'(rd_data) + wmv_pkg::SumBits'(v_q);
  end

  // variance pass control
  assign issue    = (state_q == StVar) && (iss_q < n);
  assign var_done = (state_q == StVar) && (iss_q == n) && !p1_q && !dv_q && !sv_q;

  // deviation of the entry read last cycle
  always_comb begin
    e      = {rd_data, {wmv_pkg::FracBits{1'b0}}};
    mean_x = wmv_pkg::MeanBits'(mean_q);
  end

  // ring access
  always_comb begin
    ring_wr.en   = (state_q == StUpd);
    ring_wr.addr = pos_q;
    ring_wr.data = v_q;
    rd_addr      = (state_q == StVar) ? iss_q[wmv_pkg::IdxBits-1:0] : pos_eff;
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = n;
    if (state_q == StUpd) begin
      div_req.start    = 1'b1;
      div_req.dividend = wmv_pkg::DivBits'({sum_new, {wmv_pkg::FracBits{1'b0}}});
    end else if (var_done) begin
      div_req.start    = 1'b1;
      div_req.dividend = acc_q[wmv_pkg::AccBits-1:wmv_pkg::FracBits];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StUpd;
      StUpd:   state_d = StMdiv;
      StMdiv:  if (div_done) state_d = StVar;
      StVar:   if (var_done) state_d = StVdiv;
      StVdiv:  if (div_done) state_d = StOut;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wl_q        <= wmv_pkg::LenBits'(10);
      dm_q        <= 1'b0;
      prev_q      <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      iss_q       <= '0;
      p1_q        <= 1'b0;
      dv_q        <= 1'b0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_q    <= issue;
      dv_q    <= p1_q;
      sv_q    <= dv_q;
      // register writes clear the window
      if (cfg_acc && (cfg_index_i == wmv_pkg::RegWindowLength)) begin
        wl_q <= cfg_data_i[wmv_pkg::LenBits-1:0];
      end
      if (cfg_acc && (cfg_index_i == wmv_pkg::RegDifferenceMode)) begin
        dm_q <= cfg_data_i[0];
      end
      if (clr) begin
        prev_q <= '0;
        pos_q  <= '0;
        sum_q  <= '0;
      end else if (in_acc) begin
        prev_q <= s;
        pos_q  <= pos_eff;
      end else if (state_q == StUpd) begin
        sum_q <= sum_new;
        pos_q <= (pos_inc >= n) ? '0 : pos_inc[wmv_pkg::IdxBits-1:0];
      end
      // entry read counter
      if (state_q == StMdiv) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + 1'b1;
      end
      // output register
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q <= v;
    end
    if (state_q == StMdiv && div_done) begin
      mean_q <= wmv_pkg::sat_mean(div_quot);
      acc_q  <= '0;
    end else if (sv_q) begin
      acc_q <= acc_q + wmv_pkg::AccBits'(sq_q);
    end
    if (p1_q) begin
      d_q <= (e >= mean_x) ? (e - mean_x) : (mean_x - e);
    end
    if (dv_q) begin
      sq_q <= d_q * d_q;
    end
    if (state_q == StVdiv && div_done) begin
      var_q <= wmv_pkg::sat_var(div_quot);
    end
    if (state_q == StOut && out_free) begin
      mean_out_q <= mean_q;
      var_out_q  <= var_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = wmv_pkg::OutDataBits'({var_out_q, mean_out_q});

  wmv_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .wr_i      (ring_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  wmv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

endmodule
